FILE: hdl/mpwf_pkg.sv
// ============================================================================
// mpwf_pkg
// Shared types and constants for the max pooling window forward core.
// ============================================================================
package mpwf_pkg;

	// Configuration register indexes and field widths.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IN_HEIGHT   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IN_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_ROWS = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_COLS = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_STEP    = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_COL_STEP    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_COUNT = 3'd6;

	localparam int SIZE_BITS  = 11;
	localparam int WIN_BITS   = 4;
	localparam int PLANE_BITS = 16;

	// Widths that cover the largest supported plane and window.
	localparam int EW        = 14;  // size arithmetic
	localparam int XW        = 13;  // window start offsets
	localparam int COL_BITS  = 12;  // column address
	localparam int CNT_BITS  = 5;   // window size or stride, 1..15
	localparam int LANES     = 16;  // row banks

	// Reciprocal multiply for the stride test: q = (x * RECIP[d]) >> RECIP_SHIFT.
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_BITS  = 19;
	localparam int PROD_BITS   = XW + RECIP_BITS;

	localparam logic [RECIP_BITS-1:0] RECIP [17] = '{
		19'd0,     19'd262144, 19'd131072, 19'd87382, 19'd65536, 19'd52429,
		19'd43691, 19'd37450,  19'd32768,  19'd29128, 19'd26215, 19'd23832,
		19'd21846, 19'd20165,  19'd18725,  19'd17477, 19'd16384
	};

	// One completed window handed from the front to the back.
	typedef struct packed {
		logic [COL_BITS-1:0] col_start;
		logic [CNT_BITS-1:0] ncols;
		logic [LANES-1:0]    mask;
		logic                last;
	} task_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_SCAN  = 3'b010,
		B_FLUSH = 3'b100
	} back_state_t;

	// A zero size is used as one; a size above the limit saturates.
	function automatic logic [EW-1:0] clamp(input logic [EW-1:0] v,
	                                        input logic [EW-1:0] hi);
		logic [EW-1:0] r;
		if (v == '0) begin
			r = EW'(1);
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: hdl/mpwf_ram.sv
// ============================================================================
// mpwf_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module mpwf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hdl/mpwf_fifo.sv
// ============================================================================
// mpwf_fifo
// Small first-in first-out queue for requests between the block's parts.
// ============================================================================
module mpwf_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             full,
	output logic             empty
);
	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]) && (wr_ptr_q[AW] != rd_ptr_q[AW]);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q[AW-1:0]];

	// Pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q[AW-1:0]] <= din;
		end
	end
endmodule

FILE: hdl/mpwf_front.sv
// ============================================================================
// mpwf_front
// Accepts samples, tracks the raster position, writes the row store and
// classifies each sample as the corner of a full window or not.
// ============================================================================
module mpwf_front #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [SAMPLE_BITS-1:0]              sample,
	input  logic                                wr_en,
	input  logic [mpwf_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [mpwf_pkg::CFG_DATA_BITS-1:0]  wr_data,
	input  logic                                pending,
	output logic                                task_push,
	output mpwf_pkg::task_t                     task_data,
	output logic [MAX_WINDOW-1:0]               bank_we,
	output logic [$clog2(MAX_WIDTH)-1:0]        store_addr,
	output logic [SAMPLE_BITS-1:0]              store_data
);
	import mpwf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int BW = $clog2(MAX_WINDOW);

	// Configuration registers.
	logic [SIZE_BITS-1:0]  in_height_q, in_width_q;
	logic [WIN_BITS-1:0]   window_rows_q, window_cols_q, row_step_q, col_step_q;
	logic [PLANE_BITS-1:0] plane_count_q;

	// Raster position.
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         col_q;
	logic [PLANE_BITS-1:0] plane_q;
	logic [BW-1:0]         bank_q;

	// Effective sizes.
	logic [EW-1:0]         h, w, wr, wc, rs, cs, row_e, col_e;
	logic [PLANE_BITS:0]   pc;
	logic                  accept, row_ok, col_ok, last, col_end, row_end;
	logic [XW-1:0]         x_r, x_c;

	// Classification stage.
	logic                  vld_s1, row_ok_s1, col_ok_s1, last_s1;
	logic [XW-1:0]         xr_s1, xc_s1;
	logic [PROD_BITS-1:0]  prod_r_s1, prod_c_s1;
	logic [CNT_BITS-1:0]   rs_s1, cs_s1, wr_s1, wc_s1;
	logic [BW-1:0]         bank_s1;
	logic [XW-1:0]         q_r, q_c;
	logic                  hit;
	logic [LANES-1:0]      mask;

	assign h  = clamp(EW'(in_height_q), EW'(MAX_HEIGHT));
	assign w  = clamp(EW'(in_width_q), EW'(MAX_WIDTH));
	assign wr = clamp(EW'(window_rows_q), EW'(MAX_WINDOW));
	assign wc = clamp(EW'(window_cols_q), EW'(MAX_WINDOW));
	assign rs = clamp(EW'(row_step_q), EW'(MAX_WINDOW));
	assign cs = clamp(EW'(col_step_q), EW'(MAX_WINDOW));
	assign pc = (plane_count_q == '0) ? (PLANE_BITS+1)'(1) : {1'b0, plane_count_q};

	assign row_e   = EW'(row_q);
	assign col_e   = EW'(col_q);
	assign accept  = push && !full;
	assign full    = vld_s1 || pending;
	assign row_ok  = (row_e + EW'(1)) >= wr;
	assign col_ok  = (col_e + EW'(1)) >= wc;
	assign x_r     = XW'(row_e + EW'(1) - wr);
	assign x_c     = XW'(col_e + EW'(1) - wc);
	assign col_end = (col_e + EW'(1)) >= w;
	assign row_end = (row_e + EW'(1)) >= h;
	assign last    = (({1'b0, plane_q} + (PLANE_BITS+1)'(1)) >= pc) &&
	                 ((row_e + rs) >= h) && ((col_e + cs) >= w);

	// Row store write of the accepted sample.
	always_comb begin
		bank_we = '0;
		bank_we[bank_q] = accept;
	end
	assign store_addr = col_q;
	assign store_data = sample;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q   <= SIZE_BITS'(1);
			in_width_q    <= SIZE_BITS'(1);
			window_rows_q <= WIN_BITS'(2);
			window_cols_q <= WIN_BITS'(2);
			row_step_q    <= WIN_BITS'(2);
			col_step_q    <= WIN_BITS'(2);
			plane_count_q <= PLANE_BITS'(1);
		end else if (wr_en) begin
			case (wr_index)
				CFG_IN_HEIGHT:   in_height_q   <= wr_data[SIZE_BITS-1:0];
				CFG_IN_WIDTH:    in_width_q    <= wr_data[SIZE_BITS-1:0];
				CFG_WINDOW_ROWS: window_rows_q <= wr_data[WIN_BITS-1:0];
				CFG_WINDOW_COLS: window_cols_q <= wr_data[WIN_BITS-1:0];
				CFG_ROW_STEP:    row_step_q    <= wr_data[WIN_BITS-1:0];
				CFG_COL_STEP:    col_step_q    <= wr_data[WIN_BITS-1:0];
				CFG_PLANE_COUNT: plane_count_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Raster counters advance on every accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			plane_q <= '0;
			bank_q  <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				if (row_end) begin
					row_q  <= '0;
					bank_q <= '0;
					if (({1'b0, plane_q} + (PLANE_BITS+1)'(1)) >= pc) begin
						plane_q <= '0;
					end else begin
						plane_q <= plane_q + 1'b1;
					end
				end else begin
					row_q <= row_q + 1'b1;
					if (bank_q == BW'(MAX_WINDOW - 1)) begin
						bank_q <= '0;
					end else begin
						bank_q <= bank_q + 1'b1;
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	// Stage payload: stride test products by reciprocal.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_ok_s1 <= row_ok;
			col_ok_s1 <= col_ok;
			last_s1   <= last;
			xr_s1     <= x_r;
			xc_s1     <= x_c;
			prod_r_s1 <= PROD_BITS'(x_r) * PROD_BITS'(RECIP[rs[CNT_BITS-1:0]]);
			prod_c_s1 <= PROD_BITS'(x_c) * PROD_BITS'(RECIP[cs[CNT_BITS-1:0]]);
			rs_s1     <= rs[CNT_BITS-1:0];
			cs_s1     <= cs[CNT_BITS-1:0];
			wr_s1     <= wr[CNT_BITS-1:0];
			wc_s1     <= wc[CNT_BITS-1:0];
			bank_s1   <= bank_q;
		end
	end

	// A window completes when both offsets are exact multiples of the strides.
	assign q_r = XW'(prod_r_s1 >> RECIP_SHIFT);
	assign q_c = XW'(prod_c_s1 >> RECIP_SHIFT);
	assign hit = row_ok_s1 && col_ok_s1 &&
	             (XW'(q_r * XW'(rs_s1)) == xr_s1) && (XW'(q_c * XW'(cs_s1)) == xc_s1);

	// Banks that hold the window's rows, counted back from the current bank.
	always_comb begin
		logic [BW:0] diff;
		mask = '0;
		for (int b = 0; b < MAX_WINDOW; b++) begin
			if ({1'b0, bank_s1} >= (BW+1)'(b)) begin
				diff = {1'b0, bank_s1} - (BW+1)'(b);
			end else begin
				diff = {1'b0, bank_s1} + (BW+1)'(MAX_WINDOW) - (BW+1)'(b);
			end
			mask[b] = (CNT_BITS'(diff) < wr_s1);
		end
	end

	assign task_push           = vld_s1 && hit;
	assign task_data.col_start = COL_BITS'(xc_s1);
	assign task_data.ncols     = wc_s1;
	assign task_data.mask      = mask;
	assign task_data.last      = last_s1;
endmodule

FILE: hdl/mpwf_back.sv
// ============================================================================
// mpwf_back
// Scans one window column per cycle across the window's row banks and keeps the
// running maximum, then hands the result to the output queue.
// ============================================================================
module mpwf_back #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          task_empty,
	input  mpwf_pkg::task_t               task_data,
	output logic                          task_pop,
	input  logic                          out_full,
	output logic                          busy,
	output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	input  logic [SAMPLE_BITS-1:0]        rd_data [MAX_WINDOW],
	output logic                          result_push,
	output logic [SAMPLE_BITS-1:0]        result_max,
	output logic                          result_last
);
	import mpwf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int LV = $clog2(MAX_WINDOW);
	localparam logic signed [SAMPLE_BITS-1:0] MIN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	back_state_t                   state_q;
	logic [CW-1:0]                 col_q;
	logic [CNT_BITS-1:0]           left_q;
	logic [MAX_WINDOW-1:0]         mask_q;
	logic                          last_q;
	logic                          vld_s1, vld_s2;
	logic signed [SAMPLE_BITS-1:0] colmax_s2;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic signed [SAMPLE_BITS-1:0] tree [LV+1][2**LV];

	assign busy        = (state_q != B_IDLE);
	assign task_pop    = (state_q == B_IDLE) && !task_empty && !out_full;
	assign rd_addr     = col_q;
	assign result_push = (state_q == B_FLUSH) && !vld_s1 && !vld_s2;
	assign result_max  = best_q;
	assign result_last = last_q;

	// Maximum over the window's banks for one column, as a compare tree.
	always_comb begin
		for (int l = 0; l <= LV; l++) begin
			for (int n = 0; n < 2**LV; n++) begin
				tree[l][n] = MIN_CODE;
			end
		end
		for (int n = 0; n < MAX_WINDOW; n++) begin
			if (mask_q[n]) begin
				tree[0][n] = rd_data[n];
			end
		end
		for (int l = 1; l <= LV; l++) begin
			for (int n = 0; n < 2**(LV-l); n++) begin
				if (tree[l-1][2*n+1] > tree[l-1][2*n]) begin
					tree[l][n] = tree[l-1][2*n+1];
				end else begin
					tree[l][n] = tree[l-1][2*n];
				end
			end
		end
	end

	// Sequencer: load a request, read its columns, drain the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == B_SCAN);
			vld_s2 <= vld_s1;
			case (state_q)
				B_IDLE: begin
					if (task_pop) begin
						state_q <= B_SCAN;
					end
				end
				B_SCAN: begin
					if (left_q == CNT_BITS'(1)) begin
						state_q <= B_FLUSH;
					end
				end
				B_FLUSH: begin
					if (result_push) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Window payload and running maximum.
	always_ff @(posedge clk) begin
		if (task_pop) begin
			col_q  <= CW'(task_data.col_start);
			left_q <= task_data.ncols;
			mask_q <= MAX_WINDOW'(task_data.mask);
			last_q <= task_data.last;
			best_q <= MIN_CODE;
		end else begin
			if (state_q == B_SCAN) begin
				col_q  <= col_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			if (vld_s2 && (colmax_s2 > best_q)) begin
				best_q <= colmax_s2;
			end
		end
		colmax_s2 <= tree[LV][0];
	end
endmodule

FILE: hdl/max_pool_window_forward_core.sv
// Flow: a sample that closes no window passes only the classification stage; one that
// closes a window becomes a request, its columns are read from the row banks and its
// maximum is pushed to the result queue. Intake takes no new sample while the last one
// is in the classification stage; each row bank's single read port scans one window
// column a cycle, and intake waits while a window is scanned.
// Reset: arst_n clears counters and queues and sets the configuration to its defaults; the row store is not cleared.
// ============================================================================
// max_pool_window_forward_core
// Streaming 2-D max pooling, forward pass, over a batch of planes.
// ============================================================================
module max_pool_window_forward_core #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int MAX_WINDOW  = 8,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic signed [SAMPLE_BITS-1:0]       sample,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [SAMPLE_BITS-1:0]       pooled_max,
	output logic                                last_of_batch,
	input  logic                                wr_en,
	input  logic [mpwf_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [mpwf_pkg::CFG_DATA_BITS-1:0]  wr_data
);
	import mpwf_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic                   task_push, task_pop, task_full, task_empty;
	task_t                  task_in, task_out;
	logic                   busy, pending;
	logic [MAX_WINDOW-1:0]  bank_we;
	logic [CW-1:0]          store_addr, rd_addr;
	logic [SAMPLE_BITS-1:0] store_data;
	logic [SAMPLE_BITS-1:0] rd_data [MAX_WINDOW];
	logic                   result_push, result_last, out_full;
	logic [SAMPLE_BITS-1:0] result_max;
	logic [SAMPLE_BITS:0]   out_data;

	assign pending = !task_empty || busy;

	// Front end: intake, position tracking, classification.
	mpwf_front #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .pending(pending),
		.task_push(task_push), .task_data(task_in), .bank_we(bank_we),
		.store_addr(store_addr), .store_data(store_data)
	);

	// Request queue between front and back.
	mpwf_fifo #(.WIDTH($bits(task_t)), .DEPTH(2)) u_task_q (
		.clk(clk), .arst_n(arst_n), .push(task_push), .din(task_in),
		.pop(task_pop), .dout(task_out), .full(task_full), .empty(task_empty)
	);

	// Row store: one bank per window row.
	for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
		mpwf_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_ram (
			.clk(clk), .we(bank_we[b]), .waddr(store_addr), .wdata(store_data),
			.raddr(rd_addr), .rdata(rd_data[b])
		);
	end

	// Back end: column scan and running maximum.
	mpwf_back #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n), .task_empty(task_empty), .task_data(task_out),
		.task_pop(task_pop), .out_full(out_full), .busy(busy), .rd_addr(rd_addr),
		.rd_data(rd_data), .result_push(result_push), .result_max(result_max),
		.result_last(result_last)
	);

	// Result queue toward the consumer.
	mpwf_fifo #(.WIDTH(SAMPLE_BITS + 1), .DEPTH(2)) u_out_q (
		.clk(clk), .arst_n(arst_n), .push(result_push),
		.din({result_max, result_last}), .pop(pop), .dout(out_data),
		.full(out_full), .empty(empty)
	);

	assign pooled_max    = out_data[SAMPLE_BITS:1];
	assign last_of_batch = out_data[0];

`ifndef NO_ASSERTIONS
	// The front never offers a request the queue cannot take.
	a_task_room: assert property (@(posedge clk) disable iff (!arst_n)
		task_push |-> !task_full)
		else $error("request queue overflow");

	// A finished window always finds room in the result queue.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		result_push |-> !out_full)
		else $error("result queue overflow");

	// Intake is held off while a window is being scanned.
	a_hold_intake: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> full)
		else $error("sample accepted during a window scan");

	// A request leaves the queue only when the back end is idle, and the back end starts it.
	a_one_window: assert property (@(posedge clk) disable iff (!arst_n)
		task_pop |=> busy)
		else $error("back end did not start a popped request");
`endif
endmodule

FILE: test/tb_max_pool_window_forward_core.sv
// ============================================================================
// tb_max_pool_window_forward_core
// Self-checking testbench for the streaming max pooling core. Samples are
// pushed in whole batches with random gaps. A scoreboard predicts every
// pooled maximum and end-of-batch flag and checks them in order as they
// are popped with random stalls.
// ============================================================================
module tb_max_pool_window_forward_core;
	timeunit 1ns;
	timeprecision 1ps;
	import mpwf_pkg::*;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_WINDOW  = 8;
	localparam int STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
	localparam int SETTLE      = 30;
	localparam int LIMIT       = 1000000;
	localparam int ITEM_GOAL   = 1100;

	typedef struct {
		logic signed [31:0] peak;
		logic               last;
	} pooled_t;

	// Scoreboard: a copy of the pooling state and the queue of pending maxima.
	class pool_scoreboard;
		int unsigned height_reg = 1, width_reg = 1, wrows_reg = 2, wcols_reg = 2;
		int unsigned rstep_reg = 2, cstep_reg = 2, planes_reg = 1;
		logic signed [31:0] rows_seen [STORE_DEPTH];
		int unsigned row = 0, col = 0, plane = 0;
		pooled_t pending [$];
		int errors = 0;
		int results = 0;

		function int unsigned limit(int unsigned v, int unsigned hi);
			if (v == 0) return 1;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned v);
			case (idx)
				CFG_IN_HEIGHT:   height_reg = v & 'h7FF;
				CFG_IN_WIDTH:    width_reg = v & 'h7FF;
				CFG_WINDOW_ROWS: wrows_reg = v & 'hF;
				CFG_WINDOW_COLS: wcols_reg = v & 'hF;
				CFG_ROW_STEP:    rstep_reg = v & 'hF;
				CFG_COL_STEP:    cstep_reg = v & 'hF;
				CFG_PLANE_COUNT: planes_reg = v & 'hFFFF;
				default: ;
			endcase
		endfunction

		// Samples in one whole batch under the current settings.
		function int unsigned batch_len();
			return limit(height_reg, MAX_HEIGHT) * limit(width_reg, MAX_WIDTH) *
				limit(planes_reg, 'hFFFF);
		endfunction

		function void note_sample(logic signed [31:0] s);
			int unsigned h, w, wr, wc, rs, cs, pc, r, c;
			logic signed [31:0] best;
			pooled_t res;
			h = limit(height_reg, MAX_HEIGHT);
			w = limit(width_reg, MAX_WIDTH);
			wr = limit(wrows_reg, MAX_WINDOW);
			wc = limit(wcols_reg, MAX_WINDOW);
			rs = limit(rstep_reg, MAX_WINDOW);
			cs = limit(cstep_reg, MAX_WINDOW);
			pc = limit(planes_reg, 'hFFFF);
			r = row;
			c = col;
			rows_seen[(r % MAX_WINDOW) * MAX_WIDTH + c % MAX_WIDTH] = s;
			// A window closes here when it fits and sits on the stride grid.
			if (r + 1 >= wr && c + 1 >= wc &&
					(r + 1 - wr) % rs == 0 && (c + 1 - wc) % cs == 0) begin
				best = 32'sh8000_0000;
				for (int i = 0; i < wr; i++)
					for (int j = 0; j < wc; j++)
						if (rows_seen[((r + 1 - wr + i) % MAX_WINDOW) * MAX_WIDTH +
								(c + 1 - wc + j) % MAX_WIDTH] > best)
							best = rows_seen[((r + 1 - wr + i) % MAX_WINDOW) * MAX_WIDTH +
								(c + 1 - wc + j) % MAX_WIDTH];
				res.peak = best;
				res.last = (plane + 1 >= pc && r + rs >= h && c + cs >= w);
				pending.push_back(res);
			end
			// Raster position advance, wrapping rows, planes and batches.
			if (c + 1 >= w) begin
				col = 0;
				if (r + 1 >= h) begin
					row = 0;
					plane = (plane + 1 >= pc) ? 0 : plane + 1;
				end else begin
					row = r + 1;
				end
			end else begin
				col = c + 1;
			end
		endfunction

		function void check(logic signed [31:0] peak, logic last);
			pooled_t exp_res;
			results++;
			if (pending.size() == 0) begin
				$error("unexpected result: pooled_max %h last_of_batch %b", peak, last);
				errors++;
				return;
			end
			exp_res = pending.pop_front();
			if (peak !== exp_res.peak) begin
				$error("pooled_max: expected %h, actual %h", exp_res.peak, peak);
				errors++;
			end
			if (last !== exp_res.last) begin
				$error("last_of_batch: expected %b, actual %b", exp_res.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic signed [31:0] sample = '0;
	logic empty;
	logic pop = 0;
	logic signed [31:0] pooled_max;
	logic last_of_batch;
	logic wr_en = 0;
	logic [CFG_IDX_BITS-1:0] wr_index = '0;
	logic [CFG_DATA_BITS-1:0] wr_data = '0;

	pool_scoreboard sb = new();
	int unsigned cycles = 0;
	int unsigned samples_sent = 0;

	max_pool_window_forward_core u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .pooled_max(pooled_max),
		.last_of_batch(last_of_batch), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Register write: wr_en is high for a single cycle per register.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned v);
		@(posedge clk);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= v[CFG_DATA_BITS-1:0];
		sb.write_reg(idx, v);
		@(posedge clk);
		wr_en <= 0;
	endtask

	task automatic setup(int unsigned h, int unsigned w, int unsigned wr, int unsigned wc,
			int unsigned rs, int unsigned cs, int unsigned pc);
		write_reg(CFG_IN_HEIGHT, h);
		write_reg(CFG_IN_WIDTH, w);
		write_reg(CFG_WINDOW_ROWS, wr);
		write_reg(CFG_WINDOW_COLS, wc);
		write_reg(CFG_ROW_STEP, rs);
		write_reg(CFG_COL_STEP, cs);
		write_reg(CFG_PLANE_COUNT, pc);
	endtask

	// Push one sample request after a random gap and wait until it is taken.
	task automatic push_sample(logic signed [31:0] v);
		int unsigned gap;
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		sample <= v;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_sample(v);
		samples_sent++;
	endtask

	// Wait for all pending results, then let the core settle.
	task automatic drain();
		push <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Result side: random stalls and one long hold-off to back up the core.
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 7);
			if (sb.results == 20) gap = 400;
			if (gap > 0) begin
				pop <= 0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
			while (empty) @(posedge clk);
			sb.check(pooled_max, last_of_batch);
		end
	end

	initial begin
		int unsigned h, w, wr, wc, rs, cs, pc, n;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: 4x4 plane, 2x2 windows, extreme sample values.
		setup(4, 4, 2, 2, 2, 2, 1);
		push_sample(32'sh8000_0000);
		push_sample(32'sh8000_0000);
		push_sample(32'sh7FFF_FFFF);
		push_sample(0);
		push_sample(32'sh8000_0000);
		push_sample(32'sh8000_0000);
		push_sample(-1);
		push_sample(1);
		push_sample(32'sh5555_5555);
		push_sample(32'shAAAA_AAAA);
		push_sample(-2);
		push_sample(-3);
		push_sample(32'sh0001_0000);
		push_sample(32'shFFFF_0000);
		push_sample(-5);
		push_sample(-4);
		drain();

		// Directed: every register zero, so each sample is a 1x1 window.
		setup(0, 0, 0, 0, 0, 0, 0);
		repeat (4) push_sample(rand_sample());
		drain();

		// Directed: window taller than the plane gives nothing.
		setup(2, 3, 3, 1, 1, 1, 1);
		repeat (6) push_sample(rand_sample());
		drain();

		// Oversized settings: width saturates, window columns and column stride saturate.
		setup(0, 2047, 1, 15, 1, 15, 1);
		repeat (sb.batch_len()) push_sample(rand_sample());
		drain();

		// Random phases of whole batches, mostly with windows that fit.
		while (samples_sent < ITEM_GOAL) begin
			h = $urandom_range(1, 10);
			w = $urandom_range(1, 12);
			if ($urandom_range(0, 7) == 0) begin
				wr = $urandom_range(0, 15); wc = $urandom_range(0, 15);
				rs = $urandom_range(0, 15); cs = $urandom_range(0, 15);
				h = $urandom_range(0, 12);  w = $urandom_range(0, 16);
			end else begin
				wr = $urandom_range(1, 4); wc = $urandom_range(1, 4);
				rs = $urandom_range(1, 4); cs = $urandom_range(1, 4);
			end
			pc = $urandom_range(0, 3);
			setup(h, w, wr, wc, rs, cs, pc);
			n = sb.batch_len() * $urandom_range(1, 2);
			repeat (n) push_sample(rand_sample());
			drain();
		end

		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/mpwf_pkg.sv
hdl/mpwf_ram.sv
hdl/mpwf_fifo.sv
hdl/mpwf_front.sv
hdl/mpwf_back.sv
hdl/max_pool_window_forward_core.sv
test/tb_max_pool_window_forward_core.sv
